// File: design/private_address_bridge_classifier_unit_macros.svh
// assertion macros for the private address bridge classifier
// uses clk and rst_n of the including module
`ifndef PRIVATE_ADDRESS_BRIDGE_CLASSIFIER_UNIT_MACROS_SVH
`define PRIVATE_ADDRESS_BRIDGE_CLASSIFIER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PABC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pabc check failed");
`define PABC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pabc check failed");
`else
`define PABC_ASSERT_SAME(label, ante, cons)
`define PABC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: design/pabc_pkg.sv
// shared types, codes and match functions for the classifier
// no dependencies
`default_nettype none
package pabc_pkg;

  localparam int PABC_ENTRIES = 16;

  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_MARK  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NO_ENTRY = 2'd2;

  localparam logic [31:0] NET_10     = 32'h0A00_0000;
  localparam logic [31:0] MASK_10    = 32'hFF00_0000;
  localparam logic [31:0] NET_172    = 32'hAC10_0000;
  localparam logic [31:0] MASK_172   = 32'hFFF0_0000;
  localparam logic [31:0] NET_192    = 32'hC0A8_0000;
  localparam logic [31:0] MASK_192   = 32'hFFFF_0000;
  localparam logic [31:0] NET_LINK   = 32'hA9FE_0000;
  localparam logic [31:0] MASK_LINK  = 32'hFFFF_0000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] address;
    logic [5:0]  prefix_len;
    logic [15:0] if_index;
  } in_item_t;

  typedef struct packed {
    logic       external_local;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [31:0] address;
    logic [5:0]  prefix;
    logic [15:0] ifindex;
    logic        bridge;
  } entry_t;

  function automatic logic [31:0] prefix_mask(input logic [5:0] plen);
    logic [31:0] m;
    if (plen == 6'd0) begin
      m = 32'h0;
    end else if (plen >= 6'd32) begin
      m = 32'hFFFF_FFFF;
    end else begin
      m = 32'hFFFF_FFFF << (6'd32 - plen);
    end
    return m;
  endfunction

  function automatic logic private_not_link(input logic [31:0] a);
    logic priv;
    priv = ((a & MASK_10) == NET_10) || ((a & MASK_172) == NET_172) ||
           ((a & MASK_192) == NET_192);
    return priv && ((a & MASK_LINK) != NET_LINK);
  endfunction

endpackage
`default_nettype wire

// File: design/pabc_table.sv
// network table memory, one write port and one registered read port
// depends on pabc_pkg
`default_nettype none
module pabc_table
  import pabc_pkg::*;
#(
  parameter int ENTRIES = PABC_ENTRIES,
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem [ENTRIES];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// File: design/private_address_bridge_classifier_unit.sv
// channel   direction  handshake              payload
// in_       input      in_valid / in_ready    in_item_t
// out_      output     out_valid / out_ready  out_item_t
// add and unused modes go from idle straight to done; mark and query may scan the stored entries,
// one table entry read per cycle from the single read port of pabc_table
// a new transfer is taken while a finished result waits in the output register
// reset clears the entry count and control state; the table needs no clearing
// top level of the classifier, depends on pabc_pkg, pabc_table and the macro header
`default_nettype none
`include "private_address_bridge_classifier_unit_macros.svh"
module private_address_bridge_classifier_unit
  import pabc_pkg::*;
#(
  parameter int TABLE_ENTRIES = PABC_ENTRIES
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  in_item_t         item_r, item_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  out_item_t        res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;

  logic             in_xfer;
  logic             out_free;
  logic [31:0]      ent_mask;
  logic             hit;
  logic             last;

  pabc_table #(
    .ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign ent_mask = prefix_mask(rd_data.prefix);
  assign last     = ((CNT_W'(cur_r) + CNT_W'(1)) == cnt_r);

  always_comb begin
    if (item_r.mode == MODE_MARK) begin
      hit = (rd_data.ifindex == item_r.if_index);
    end else begin
      hit = rd_data.bridge && ((item_r.address & ent_mask) == (rd_data.address & ent_mask));
    end
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    cnt_nxt       = cnt_r;
    cur_nxt       = cur_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = cnt_r[IDX_W-1:0];
    wr_data       = '{address: in_data.address, prefix: in_data.prefix_len,
                      ifindex: in_data.if_index, bridge: 1'b0};
    rd_en         = 1'b0;
    rd_addr       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          item_nxt  = in_data;
          cur_nxt   = '0;
          res_nxt   = '{external_local: 1'b0, status: ST_OK};
          state_nxt = S_DONE;
          case (in_data.mode)
            MODE_ADD: begin
              if (cnt_r == FULL_CNT) begin
                res_nxt.status = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            MODE_MARK: begin
              if (cnt_r == '0) begin
                res_nxt.status = ST_NO_ENTRY;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_SCAN;
              end
            end
            MODE_QUERY: begin
              if (cnt_r == '0 || !private_not_link(in_data.address)) begin
                res_nxt.external_local = private_not_link(in_data.address);
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_nxt = S_DONE;
          if (item_r.mode == MODE_MARK) begin
            wr_en          = 1'b1;
            wr_addr        = cur_r;
            wr_data        = rd_data;
            wr_data.bridge = 1'b1;
            res_nxt.status = ST_OK;
          end else begin
            res_nxt.external_local = 1'b0;
          end
        end else if (last) begin
          state_nxt = S_DONE;
          if (item_r.mode == MODE_MARK) begin
            res_nxt.status = ST_NO_ENTRY;
          end else begin
            res_nxt.external_local = 1'b1;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = cur_r + IDX_W'(1);
          cur_nxt = cur_r + IDX_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    cur_r      <= cur_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PABC_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_r <= FULL_CNT)
  `PABC_ASSERT_NEXT(a_busy_after_xfer, in_xfer, state_r != S_IDLE)
  `PABC_ASSERT_NEXT(a_result_loaded, state_r == S_DONE && out_free, out_valid_r)
  `PABC_ASSERT_SAME(a_scan_in_range, state_r == S_SCAN, CNT_W'(cur_r) < cnt_r)

endmodule
`default_nettype wire

// File: tb/tb_private_address_bridge_classifier_unit.sv
// self-checking testbench for the private address bridge classifier unit
// a local copy of the network table predicts each transfer's class and status
// depends on pabc_pkg and private_address_bridge_classifier_unit
`default_nettype none
module tb_private_address_bridge_classifier_unit
  import pabc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned STUCK_LIMIT = 4000;
  localparam int unsigned RANDOM_ITEMS = 780;

  class address_class_ledger;
    logic [31:0] net_addr [PABC_ENTRIES];
    logic [5:0]  net_plen [PABC_ENTRIES];
    logic [15:0] net_ifx [PABC_ENTRIES];
    bit          net_bridge [PABC_ENTRIES];
    int unsigned net_count;
    out_item_t   pending [$];
    int unsigned errors;

    function new();
      net_count = 0;
      errors = 0;
      foreach (net_bridge[k]) net_bridge[k] = 1'b0;
    endfunction

    function logic [31:0] subnet_mask(logic [5:0] plen);
      return (plen >= 6'd32) ? 32'hFFFF_FFFF : ~(32'hFFFF_FFFF >> plen);
    endfunction

    function logic external_local(logic [31:0] a);
      logic [31:0] m;
      logic priv;
      logic hit;
      priv = ((a & MASK_10) == NET_10) || ((a & MASK_172) == NET_172) ||
             ((a & MASK_192) == NET_192);
      hit = 1'b0;
      for (int unsigned k = 0; k < net_count; k++) begin
        m = subnet_mask(net_plen[k]);
        if (net_bridge[k] && ((a & m) == (net_addr[k] & m))) begin
          hit = 1'b1;
        end
      end
      return priv && ((a & MASK_LINK) != NET_LINK) && !hit;
    endfunction

    function void note_input(in_item_t it);
      out_item_t want;
      want = '0;
      want.status = ST_OK;
      case (it.mode)
        MODE_ADD: begin
          if (net_count == PABC_ENTRIES) begin
            want.status = ST_FULL;
          end else begin
            net_addr[net_count] = it.address;
            net_plen[net_count] = it.prefix_len;
            net_ifx[net_count] = it.if_index;
            net_bridge[net_count] = 1'b0;
            net_count++;
          end
        end
        MODE_MARK: begin
          want.status = ST_NO_ENTRY;
          for (int unsigned k = 0; k < net_count; k++) begin
            if (want.status == ST_NO_ENTRY && net_ifx[k] == it.if_index) begin
              net_bridge[k] = 1'b1;
              want.status = ST_OK;
            end
          end
        end
        MODE_QUERY: begin
          want.external_local = external_local(it.address);
        end
        default: begin
        end
      endcase
      pending = {pending, want};
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t unexpected result: expected none, actual ext %0b status %0d",
                 $time, got.external_local, got.status);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.external_local !== want.external_local) begin
        $display("%0t external_local mismatch: expected %0b, actual %0b",
                 $time, want.external_local, got.external_local);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t status mismatch: expected %0d, actual %0d",
                 $time, want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  bit          gaps_on = 1'b1;
  int unsigned stuck_cycles = 0;
  address_class_ledger ledger;

  private_address_bridge_classifier_unit #(
    .TABLE_ENTRIES(PABC_ENTRIES)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      ledger.check_result(out_data);
    end
    out_ready <= !gaps_on || ($urandom_range(99) >= 31);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("tb_private_address_bridge_classifier_unit NOT OK");
    $finish;
  end

  task automatic send(input in_item_t it);
    while (gaps_on && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    ledger.note_input(it);
  endtask

  task automatic send_fields(input logic [1:0] mode, input logic [31:0] addr,
                             input logic [5:0] plen, input logic [15:0] ifx);
    in_item_t it;
    it.mode = mode;
    it.address = addr;
    it.prefix_len = plen;
    it.if_index = ifx;
    send(it);
  endtask

  function automatic logic [31:0] private_address();
    case ($urandom_range(3))
      0: return {8'h0A, 24'($urandom)};
      1: return {12'hAC1, 20'($urandom)};
      2: return {16'hC0A8, 16'($urandom)};
      default: return {16'hA9FE, 16'($urandom)};
    endcase
  endfunction

  function automatic logic [31:0] query_address();
    int unsigned s;
    int unsigned idx;
    logic [31:0] m;
    s = $urandom_range(9);
    if (s < 4 && ledger.net_count > 0) begin
      idx = $urandom_range(ledger.net_count - 1);
      m = ledger.subnet_mask(ledger.net_plen[idx]);
      if (s == 3) begin
        return ledger.net_addr[idx] ^ (32'h1 << $urandom_range(31));
      end
      return (ledger.net_addr[idx] & m) | ($urandom & ~m);
    end
    if (s < 8) begin
      return private_address();
    end
    return $urandom;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int unsigned r;
    r = $urandom_range(99);
    it.address = $urandom;
    it.prefix_len = 6'($urandom);
    it.if_index = 16'($urandom);
    if (r < 6) begin
      it.mode = MODE_ADD;
      if ($urandom_range(4) != 0) it.address = private_address();
      if ($urandom_range(9) == 0) begin
        it.prefix_len = 6'($urandom_range(1, 63));
      end else begin
        it.prefix_len = 6'($urandom_range(12, 32));
      end
      if ($urandom_range(3) != 0) it.if_index = 16'($urandom_range(9));
    end else if (r < 24) begin
      it.mode = MODE_MARK;
      if ($urandom_range(9) < 7) it.if_index = 16'($urandom_range(9));
      // the zero prefix entry on index ffff stays clear until the closing part
      if (it.if_index == 16'hFFFF) it.if_index = 16'hFFFE;
    end else if (r < 97) begin
      it.mode = MODE_QUERY;
      it.address = query_address();
    end else begin
      it.mode = MODE_UNUSED;
    end
    return it;
  endfunction

  initial begin
    ledger = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_fields(MODE_QUERY, 32'h0A01_0203, 6'd0, 16'd0);
    send_fields(MODE_QUERY, 32'hAC1F_FFFF, 6'd0, 16'd0);
    send_fields(MODE_QUERY, 32'hAC20_0001, 6'd0, 16'd0);
    send_fields(MODE_QUERY, 32'hC0A8_0000, 6'd0, 16'd0);
    send_fields(MODE_QUERY, 32'hA9FE_0101, 6'd0, 16'd0);
    send_fields(MODE_QUERY, 32'h0000_0000, 6'd0, 16'd0);
    send_fields(MODE_QUERY, 32'hFFFF_FFFF, 6'h3F, 16'hFFFF);
    send_fields(MODE_MARK, 32'hFFFF_FFFF, 6'h3F, 16'd5);
    send_fields(MODE_ADD, 32'h0A01_0000, 6'd16, 16'd3);
    send_fields(MODE_ADD, 32'hC0A8_0700, 6'd24, 16'd3);
    send_fields(MODE_ADD, 32'hAC14_0000, 6'd63, 16'd0);
    send_fields(MODE_ADD, 32'h0000_0000, 6'd0, 16'hFFFF);
    send_fields(MODE_MARK, 32'h0, 6'd0, 16'd3);
    send_fields(MODE_MARK, 32'h0, 6'd0, 16'd3);
    send_fields(MODE_QUERY, 32'h0A01_0909, 6'd0, 16'd0);
    send_fields(MODE_QUERY, 32'hC0A8_0705, 6'd0, 16'd0);
    send_fields(MODE_MARK, 32'h1234_5678, 6'd9, 16'd0);
    send_fields(MODE_QUERY, 32'hAC14_0000, 6'd0, 16'd0);
    send_fields(MODE_QUERY, 32'hAC14_0001, 6'd0, 16'd0);
    send_fields(MODE_UNUSED, 32'hFFFF_FFFF, 6'h3F, 16'hFFFF);
    send_fields(MODE_MARK, 32'h0, 6'd0, 16'h1234);

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 300) gaps_on <= 1'b0;
      if (n == 450) gaps_on <= 1'b1;
      if (n == 600) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (ledger.pending.size() != 0);
      end
      send(random_item());
    end

    // zero prefix bridge covers every address
    send_fields(MODE_MARK, 32'h0, 6'd0, 16'hFFFF);
    send_fields(MODE_QUERY, 32'h0A00_0001, 6'd0, 16'd0);
    send_fields(MODE_QUERY, 32'hC0A8_0101, 6'd0, 16'd0);
    send_fields(MODE_ADD, 32'hC0A8_0100, 6'd24, 16'd7);

    in_valid <= 1'b0;
    while (ledger.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("tb_private_address_bridge_classifier_unit OK");
    end else begin
      $display("tb_private_address_bridge_classifier_unit NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
+incdir+design
design/pabc_pkg.sv
design/pabc_table.sv
design/private_address_bridge_classifier_unit.sv
tb/tb_private_address_bridge_classifier_unit.sv
